[rtl/lsrp_pkg.sv]
// shared types and codes for the lifo stack with reverse and pair check
`default_nettype none

package lsrp_pkg;

  // default sizes
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_WORD_WIDTH  = 16;

  // fixed field widths of the request and response words
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_TOP = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REVERSE = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_PAIR    = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  top_value;
    logic                top_valid;
    logic [STATUS_W-1:0] status;
    logic                pair_found;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/lifo_stack_with_reverse_and_pair_check.sv]
// lifo stack: a push that fits, clear and empty pop go straight to the result register;
// other actions read the top word first unless the stack is empty, and a held response
// register stalls the result. pair query: one store read per cycle through one ram port
// next request taken once the block returns to idle
// synchronous active high reset empties the stack and clears direction and base
// entry store contents stay undefined after reset, no clearing pass
`default_nettype none

module lifo_stack_with_reverse_and_pair_check #(
  parameter int STACK_DEPTH = lsrp_pkg::DEF_STACK_DEPTH,
  parameter int WORD_WIDTH  = lsrp_pkg::DEF_WORD_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire lsrp_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output lsrp_pkg::rsp_t     rsp
);

  import lsrp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int OW = (WORD_WIDTH < VALUE_W) ? WORD_WIDTH : VALUE_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_READ_TOP,
    S_TOP_WAIT,
    S_DONE
  } state_t;

  state_t state;

  // stack state
  logic [CW-1:0] count;
  logic [AW-1:0] base;
  logic          flipped;

  // per word working registers
  logic [ACTION_W-1:0]   act_q;
  logic [WORD_WIDTH-1:0] word_q;
  logic [AW-1:0]         scan_pos;
  logic                  rd_pend;
  logic                  prev_match;
  logic                  pair_q;
  logic [VALUE_W-1:0]    res_top;
  logic                  res_valid;
  logic [STATUS_W-1:0]   res_status;

  // shared slot mapper and store port
  logic [CW-1:0]         count_m1;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         slot;
  logic                  accept;
  logic                  we;
  logic                  full;
  logic                  cur_match;
  logic [WORD_WIDTH-1:0] req_word;
  logic [WORD_WIDTH-1:0] rdata;

  assign count_m1  = count - 1'b1;
  assign full      = (count == FULL_COUNT);
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign req_word  = WORD_WIDTH'(req.value[OW-1:0]);
  assign we        = accept && (req.action == ACT_PUSH) && !full;
  assign cur_match = (rdata == word_q);

  // position that the slot mapper works on this cycle
  always_comb begin
    unique case (state)
      S_IDLE:  pos = (req.action == ACT_PUSH) ? count[AW-1:0] : count_m1[AW-1:0];
      S_SCAN:  pos = scan_pos;
      default: pos = count_m1[AW-1:0];
    endcase
  end

  lsrp_slot #(
    .DEPTH (STACK_DEPTH)
  ) u_slot (
    .base    (base),
    .flipped (flipped),
    .pos     (pos),
    .slot    (slot)
  );

  lsrp_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata (req_word),
    .raddr (slot),
    .rdata (rdata)
  );

  // sequencer, stack state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      base       <= '0;
      flipped    <= 1'b0;
      rd_pend    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);

      // pair compare on each word returned by the scan
      if (rd_pend) begin
        pair_q     <= pair_q | (prev_match & cur_match);
        prev_match <= cur_match;
      end

      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act_q      <= req.action;
            word_q     <= req_word;
            res_status <= ST_OK;
            pair_q     <= 1'b0;
            prev_match <= 1'b0;
            scan_pos   <= '0;
            priority case (req.action)
              ACT_PUSH: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_READ_TOP;
                end else begin
                  count     <= count + 1'b1;
                  res_top   <= VALUE_W'(req_word[OW-1:0]);
                  res_valid <= 1'b1;
                  state     <= S_DONE;
                end
              end
              ACT_POP, ACT_POP_TOP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  res_top    <= '0;
                  res_valid  <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  state <= S_READ_TOP;
                end
              end
              ACT_CLEAR: begin
                count     <= '0;
                base      <= '0;
                flipped   <= 1'b0;
                res_top   <= '0;
                res_valid <= 1'b0;
                state     <= S_DONE;
              end
              ACT_REVERSE: begin
                // old top slot becomes the new bottom
                if (count >= CW'(2)) begin
                  base    <= slot;
                  flipped <= ~flipped;
                end
                state <= S_READ_TOP;
              end
              ACT_PAIR: begin
                state <= (count >= CW'(2)) ? S_SCAN : S_READ_TOP;
              end
              default: begin
                state <= S_READ_TOP;
              end
            endcase
          end
        end

        // issue one store read per logical position, bottom upward
        S_SCAN: begin
          if (CW'(scan_pos) == count_m1) begin
            state <= S_SCAN_LAST;
          end else begin
            scan_pos <= scan_pos + 1'b1;
          end
        end

        // last scan word is compared this cycle
        S_SCAN_LAST: begin
          state <= S_READ_TOP;
        end

        S_READ_TOP: begin
          if (count == '0) begin
            res_top   <= '0;
            res_valid <= 1'b0;
            state     <= S_DONE;
          end else begin
            state <= S_TOP_WAIT;
          end
        end

        S_TOP_WAIT: begin
          res_top   <= VALUE_W'(rdata[OW-1:0]);
          res_valid <= 1'b1;
          if (act_q == ACT_POP || act_q == ACT_POP_TOP) begin
            count <= count_m1;
          end
          state <= S_DONE;
        end

        // hand the result over once the response register is free
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.top_value   <= res_top;
            rsp.top_valid   <= res_valid;
            rsp.status      <= res_status;
            rsp.pair_found  <= (act_q == ACT_PAIR) ? pair_q : 1'b0;
            rsp.entry_count <= COUNT_W'(count);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // fill count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond stack depth");

  // clear empties the stack in the next cycle
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_CLEAR) |=> (count == '0))
    else $error("clear did not empty the stack");

  // a refused push reports a valid top
  a_full_has_top: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> rsp.top_valid)
    else $error("full status without a valid top");

  // an empty pop reports no top
  a_empty_no_top: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_EMPTY) |-> (!rsp.top_valid && rsp.top_value == '0))
    else $error("empty status with a top word");
`endif

endmodule

`default_nettype wire

[rtl/lsrp_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module lsrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/lsrp_slot.sv]
// maps a logical stack position onto a physical slot of the circular store
`default_nettype none

module lsrp_slot #(
  parameter int DEPTH = 16
) (
  input  wire logic [$clog2(DEPTH)-1:0] base,
  input  wire logic                     flipped,
  input  wire logic [$clog2(DEPTH)-1:0] pos,
  output logic      [$clog2(DEPTH)-1:0] slot
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  logic [AW:0] fwd;
  logic [AW:0] rev;
  logic [AW:0] sel;

  // base plus or minus offset, folded back once into the store range
  always_comb begin
    fwd  = {1'b0, base} + {1'b0, pos};
    rev  = {1'b0, base} + DEPTH_W - {1'b0, pos};
    sel  = flipped ? rev : fwd;
    slot = (sel >= DEPTH_W) ? AW'(sel - DEPTH_W) : AW'(sel);
  end

endmodule

`default_nettype wire

[tb/lifo_stack_with_reverse_and_pair_check_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the lifo stack with reverse and pair check
module lifo_stack_with_reverse_and_pair_check_test;
  import lsrp_pkg::*;

  localparam int DEPTH        = DEF_STACK_DEPTH;
  localparam int RANDOM_WORDS = 1900;
  localparam int CALM_WORDS   = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 40;

  // action codes the block treats as no-ops
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  // random traffic modes
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;

  // tracks stack contents and holds the responses still owed by the block
  class stack_tracker;
    logic [VALUE_W-1:0] words [DEPTH];
    int unsigned        used;
    logic [3:0]         base;
    bit                 flipped;
    rsp_t               pending [$];
    int unsigned        mismatches;

    function new();
      foreach (words[k]) words[k] = '0;
      used       = 0;
      base       = '0;
      flipped    = 1'b0;
      mismatches = 0;
    endfunction

    // physical slot of a position counted from the bottom
    function logic [3:0] slot(int unsigned pos);
      return flipped ? base - 4'(pos) : base + 4'(pos);
    endfunction

    function rsp_t with_top(rsp_t r);
      if (used != 0) begin
        r.top_value = words[slot(used - 1)];
        r.top_valid = 1'b1;
      end
      return r;
    endfunction

    function string describe(rsp_t r);
      return $sformatf("top=%h valid=%b status=%0d pair=%b count=%0d",
                       r.top_value, r.top_valid, r.status, r.pair_found, r.entry_count);
    endfunction

    // work out the response owed for one accepted request word
    function void note_request(req_t w);
      rsp_t r;
      r = '0;
      case (w.action)
        ACT_PUSH: begin
          if (used >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            words[slot(used)] = w.value;
            used++;
          end
          r = with_top(r);
        end
        ACT_POP, ACT_POP_TOP: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r = with_top(r);
            used--;
          end
        end
        ACT_CLEAR: begin
          used    = 0;
          base    = '0;
          flipped = 1'b0;
        end
        ACT_REVERSE: begin
          // new bottom is the old top, direction flips
          if (used >= 2) begin
            base    = slot(used - 1);
            flipped = !flipped;
          end
          r = with_top(r);
        end
        ACT_PAIR: begin
          for (int i = 0; i + 1 < used; i++) begin
            if (words[slot(i)] == w.value && words[slot(i + 1)] == w.value)
              r.pair_found = 1'b1;
          end
          r = with_top(r);
        end
        default: begin
          r = with_top(r);
        end
      endcase
      r.entry_count = COUNT_W'(used);
      pending.push_back(r);
    endfunction

    // compare one accepted response word with the oldest owed one
    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected response: %s", describe(got));
        return;
      end
      want = pending.pop_front();
      if (got.top_value !== want.top_value || got.top_valid !== want.top_valid ||
          got.status !== want.status || got.pair_found !== want.pair_found ||
          got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("response mismatch: expected %s, got %s", describe(want), describe(got));
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  req_t        req       = '0;
  logic        rsp_ready = 1'b0;
  logic        req_ready;
  logic        rsp_valid;
  rsp_t        rsp;

  bit          no_idling   = 1'b0;
  int unsigned cycle_count = 0;
  int          stall_left  = 0;
  stack_tracker tracker;

  lifo_stack_with_reverse_and_pair_check i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lifo_stack_with_reverse_and_pair_check] ERROR");
      $finish;
    end
  end

  // response side: check accepted words, stall in short bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) tracker.check_response(rsp);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // offer one request word, with an optional idle burst first
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    int   gap;
    req_t w;
    w.action = act;
    w.value  = val;
    gap = (!no_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    tracker.note_request(w);
  endtask

  initial begin
    int                  mode;
    int                  roll;
    int                  push_pct;
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty stack corner cases
    send_word(ACT_POP, 16'h0000);
    send_word(ACT_POP_TOP, 16'hFFFF);
    send_word(ACT_PAIR, 16'h0000);
    send_word(ACT_REVERSE, 16'h0000);
    send_word(ACT_SPARE_A, 16'hFFFF);
    send_word(ACT_SPARE_B, 16'h0000);
    // one entry: query and reverse see a short stack
    send_word(ACT_PUSH, 16'hFFFF);
    send_word(ACT_PAIR, 16'hFFFF);
    send_word(ACT_REVERSE, 16'hFFFF);
    // adjacent pair present and absent
    send_word(ACT_PUSH, 16'hFFFF);
    send_word(ACT_PAIR, 16'hFFFF);
    send_word(ACT_PAIR, 16'h0000);
    send_word(ACT_PUSH, 16'h0000);
    send_word(ACT_PUSH, 16'h1234);
    send_word(ACT_REVERSE, 16'h0000);
    send_word(ACT_PAIR, 16'hFFFF);
    send_word(ACT_POP_TOP, 16'h0000);
    send_word(ACT_POP, 16'h0000);
    send_word(ACT_SPARE_A, 16'h5A5A);
    send_word(ACT_SPARE_B, 16'hA5A5);
    send_word(ACT_CLEAR, 16'hFFFF);
    send_word(ACT_POP, 16'h0000);
    send_word(ACT_PUSH, 16'hA5A5);
    send_word(ACT_PAIR, 16'hA5A5);

    // random traffic in fill, drain and mixed phases
    mode = MODE_FILL;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      no_idling = ((n / 50) % 4 == 3) || (n >= RANDOM_WORDS - CALM_WORDS);

      // let the block drain completely once
      if (n == RANDOM_WORDS / 2) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending.size() != 0);
      end

      push_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 20 : 40;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        act = ACT_PUSH;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25)      act = ACT_POP;
        else if (roll < 45) act = ACT_POP_TOP;
        else if (roll < 47) act = ACT_CLEAR;
        else if (roll < 66) act = ACT_REVERSE;
        else if (roll < 94) act = ACT_PAIR;
        else                act = roll[0] ? ACT_SPARE_A : ACT_SPARE_B;
      end

      // mostly a small pool so pairs show up, otherwise any word
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 3))
          0:       val = 16'h0000;
          1:       val = 16'hFFFF;
          2:       val = 16'h8000;
          default: val = 16'h0001;
        endcase
      end else begin
        val = VALUE_W'($urandom);
      end
      send_word(act, val);
    end

    // wait out the last responses
    req_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("[lifo_stack_with_reverse_and_pair_check] OK");
    end else begin
      $display("[lifo_stack_with_reverse_and_pair_check] ERROR");
    end
    $finish;
  end

endmodule
